@@ hw/rtl/bfsp_pkg.sv @@
// Shared types and constants for the shortest-path search block.
package bfsp_pkg;

    localparam int DIST_W      = 32;
    localparam int VTX_FIELD_W = 6;
    localparam int IDX_FIELD_W = 10;
    localparam int WT_FIELD_W  = 16;
    localparam int NV_W        = 7;
    localparam int NE_W        = 11;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 40;

    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_RUN   = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NUM_VERTICES = 2'd0,
        CFG_NUM_EDGES    = 2'd1,
        CFG_SOURCE       = 2'd2,
        CFG_DIRECTED     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                     improve;
        logic signed [DIST_W-1:0] sum;
    } relax_res_t;

endpackage

@@ hw/rtl/bfsp_relax_unit.sv @@
// Saturating add and compare for one edge relaxation.
module bfsp_relax_unit
(
    input  logic                               from_reached,
    input  logic                               to_reached,
    input  logic signed [bfsp_pkg::DIST_W-1:0] from_dist,
    input  logic signed [bfsp_pkg::DIST_W-1:0] to_dist,
    input  logic signed [bfsp_pkg::DIST_W-1:0] weight,
    output bfsp_pkg::relax_res_t               res
);

    logic signed [bfsp_pkg::DIST_W:0]   wide_sum;
    logic signed [bfsp_pkg::DIST_W-1:0] sat_sum;

    assign wide_sum = {from_dist[bfsp_pkg::DIST_W-1], from_dist}
                    + {weight[bfsp_pkg::DIST_W-1], weight};

    // Clamp on overflow: the top two bits disagree.
    always_comb
    begin
        unique case (wide_sum[bfsp_pkg::DIST_W:bfsp_pkg::DIST_W-1])
            2'b01:   sat_sum = {1'b0, {(bfsp_pkg::DIST_W-1){1'b1}}};
            2'b10:   sat_sum = {1'b1, {(bfsp_pkg::DIST_W-1){1'b0}}};
            default: sat_sum = wide_sum[bfsp_pkg::DIST_W-1:0];
        endcase
    end

    assign res.sum     = sat_sum;
    assign res.improve = from_reached && (!to_reached || (sat_sum < to_dist));

endmodule

@@ hw/rtl/bellman_ford_shortest_paths_top.sv @@
// Top level of the Bellman-Ford shortest-path search block.
//
//   Configure num_vertices, num_edges, source_vertex and directed_mode on the
//   write port (cfg_wr_en, cfg_addr, cfg_wdata) while the block is idle.
//   Each input word on s_* with s_tuser = 0 stores one edge at edge_index;
//   store words may follow back to back.
//   A word with s_tuser = 1 starts a search. s_tready stays low until the
//   last distance word has been loaded into the output register.
//   Each edge relaxation is a read-modify-write over the distance memory:
//   edge read, distance read, forward update, and in undirected mode a
//   reverse update (skipped in the check pass); an edge with an endpoint
//   out of range drops out after the distance read.
//   Results leave on m_* one word per vertex in vertex order; m_tlast marks
//   the final vertex and m_tuser carries the negative-cycle flag. When the
//   receiver stalls, the current word holds in the output register and the
//   sequencer waits before loading the next one.
//   Reset clears the control state, the reached flags and the configuration
//   (vertex count to 1); the edge memory holds nothing defined until written.
module bellman_ford_shortest_paths_top
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [bfsp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [bfsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // edge_index[9:0], edge_from[15:10], edge_to[21:16], edge_weight[37:22]
    input  logic [bfsp_pkg::IN_DATA_W-1:0]       s_tdata,
    // action[0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // vertex[5:0], distance[37:6], reachable[38]
    output logic [bfsp_pkg::OUT_DATA_W-1:0]      m_tdata,
    // negative_cycle[0]
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    localparam int VW   = $clog2(MAX_VERTICES);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int WB   = (WEIGHT_BITS < bfsp_pkg::WT_FIELD_W) ? WEIGHT_BITS
                                                               : bfsp_pkg::WT_FIELD_W;
    localparam int VF   = bfsp_pkg::VTX_FIELD_W;
    localparam int EW   = 2 * VF + WB;
    localparam int DW   = bfsp_pkg::DIST_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_EDGE_RD,
        S_DIST_RD,
        S_FWD,
        S_REV,
        S_OUT_RD,
        S_OUT_LOAD
    } state_t;

    state_t state_reg;

    // configuration
    logic [bfsp_pkg::NV_W-1:0] num_vertices_reg;
    logic [bfsp_pkg::NE_W-1:0] num_edges_reg;
    logic [VF-1:0]             source_reg;
    logic                      directed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= bfsp_pkg::NV_W'(1);
            num_edges_reg    <= '0;
            source_reg       <= '0;
            directed_reg     <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (bfsp_pkg::cfg_idx_t'(cfg_addr))
                bfsp_pkg::CFG_NUM_VERTICES: num_vertices_reg <= cfg_wdata[bfsp_pkg::NV_W-1:0];
                bfsp_pkg::CFG_NUM_EDGES:    num_edges_reg    <= cfg_wdata[bfsp_pkg::NE_W-1:0];
                bfsp_pkg::CFG_SOURCE:       source_reg       <= cfg_wdata[VF-1:0];
                bfsp_pkg::CFG_DIRECTED:     directed_reg     <= cfg_wdata[0];
            endcase
        end
    end

    // Clamp counts into the supported range.
    logic [bfsp_pkg::NV_W-1:0] nv_eff;
    logic [bfsp_pkg::NE_W-1:0] ne_eff;
    logic                      src_ok;

    always_comb
    begin
        priority if (num_vertices_reg == '0)
            nv_eff = bfsp_pkg::NV_W'(1);
        else if (32'(num_vertices_reg) > 32'(MAX_VERTICES))
            nv_eff = bfsp_pkg::NV_W'(MAX_VERTICES);
        else
            nv_eff = num_vertices_reg;
        if (32'(num_edges_reg) > 32'(MAX_EDGES))
            ne_eff = bfsp_pkg::NE_W'(MAX_EDGES);
        else
            ne_eff = num_edges_reg;
    end

    assign src_ok = {1'b0, source_reg} < nv_eff;

    // input word fields
    logic [bfsp_pkg::IDX_FIELD_W-1:0] in_index;
    logic [VF-1:0]                    in_from;
    logic [VF-1:0]                    in_to;
    logic [bfsp_pkg::WT_FIELD_W-1:0]  in_weight;
    logic                             in_accept;

    assign in_index  = s_tdata[9:0];
    assign in_from   = s_tdata[15:10];
    assign in_to     = s_tdata[21:16];
    assign in_weight = s_tdata[37:22];
    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // edge memory: {weight, to, from}
    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [EW-1:0] edge_rd_reg;
    logic          edge_we;
    logic [EA_W-1:0] edge_waddr;
    logic [bfsp_pkg::NE_W-1:0] e_reg;

    assign edge_we    = in_accept && (s_tuser == bfsp_pkg::ACT_STORE)
                     && (32'(in_index) < 32'(MAX_EDGES));
    assign edge_waddr = EA_W'(in_index);

    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_waddr] <= {in_weight[WB-1:0], in_to, in_from};
        if (state_reg == S_EDGE_RD)
            edge_rd_reg <= edge_mem[EA_W'(e_reg)];
    end

    logic [VF-1:0]        ed_from;
    logic [VF-1:0]        ed_to;
    logic signed [DW-1:0] ed_weight;
    logic                 ed_ok;
    logic [VW-1:0]        ed_a;
    logic [VW-1:0]        ed_b;

    assign ed_from   = edge_rd_reg[VF-1:0];
    assign ed_to     = edge_rd_reg[2*VF-1:VF];
    assign ed_weight = {{(DW-WB){edge_rd_reg[EW-1]}}, edge_rd_reg[EW-1:2*VF]};
    assign ed_ok     = ({1'b0, ed_from} < nv_eff) && ({1'b0, ed_to} < nv_eff);
    assign ed_a      = ed_from[VW-1:0];
    assign ed_b      = ed_to[VW-1:0];

    // distance memory: one write port, two registered read ports
    logic signed [DW-1:0] dist_mem [MAX_VERTICES];
    logic signed [DW-1:0] dist_a_rd_reg;
    logic signed [DW-1:0] dist_b_rd_reg;
    logic                 dm_we;
    logic [VW-1:0]        dm_waddr;
    logic signed [DW-1:0] dm_wdata;
    logic                 rd_a_en;
    logic [VW-1:0]        rd_a_addr;
    logic                 rd_b_en;

    logic [bfsp_pkg::NV_W-1:0] v_reg;
    logic [bfsp_pkg::NV_W-1:0] pass_reg;
    logic                      check_reg;
    logic [MAX_VERTICES-1:0]   reached_reg;
    logic [MAX_VERTICES-1:0]   reached_init;
    logic                      cycle_reg;
    logic signed [DW-1:0]      da_reg;
    logic signed [DW-1:0]      db_reg;

    // Reached flags at run start: only the source, when it is in range.
    always_comb
    begin
        reached_init = '0;
        if (src_ok)
            reached_init[source_reg[VW-1:0]] = 1'b1;
    end

    bfsp_pkg::relax_res_t fwd_res;
    bfsp_pkg::relax_res_t rev_res;

    bfsp_relax_unit u_fwd
    (
        .from_reached (reached_reg[ed_a]),
        .to_reached   (reached_reg[ed_b]),
        .from_dist    (dist_a_rd_reg),
        .to_dist      (dist_b_rd_reg),
        .weight       (ed_weight),
        .res          (fwd_res)
    );

    // Reverse step sees the flags and values the forward step just left.
    bfsp_relax_unit u_rev
    (
        .from_reached (reached_reg[ed_b]),
        .to_reached   (reached_reg[ed_a]),
        .from_dist    (db_reg),
        .to_dist      (da_reg),
        .weight       (ed_weight),
        .res          (rev_res)
    );

    always_comb
    begin
        dm_we     = 1'b0;
        dm_waddr  = ed_b;
        dm_wdata  = fwd_res.sum;
        rd_a_en   = 1'b0;
        rd_a_addr = ed_a;
        rd_b_en   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                dm_we    = src_ok;
                dm_waddr = source_reg[VW-1:0];
                dm_wdata = '0;
            end
            S_DIST_RD:
            begin
                rd_a_en = ed_ok;
                rd_b_en = ed_ok;
            end
            S_FWD:
            begin
                dm_we = fwd_res.improve && !check_reg;
            end
            S_REV:
            begin
                dm_we    = rev_res.improve;
                dm_waddr = ed_a;
                dm_wdata = rev_res.sum;
            end
            S_OUT_RD:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = v_reg[VW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dm_we)
            dist_mem[dm_waddr] <= dm_wdata;
        if (rd_a_en)
            dist_a_rd_reg <= dist_mem[rd_a_addr];
        if (rd_b_en)
            dist_b_rd_reg <= dist_mem[ed_b];
    end

    // reached flags, cycle flag and forwarded values for the reverse step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= '0;
            cycle_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_INIT:
                begin
                    reached_reg <= reached_init;
                    cycle_reg   <= 1'b0;
                end
                S_FWD:
                begin
                    if (fwd_res.improve)
                    begin
                        if (check_reg)
                            cycle_reg <= 1'b1;
                        else
                            reached_reg[ed_b] <= 1'b1;
                    end
                end
                S_REV:
                begin
                    if (rev_res.improve)
                        reached_reg[ed_a] <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FWD)
        begin
            db_reg <= fwd_res.improve ? fwd_res.sum : dist_b_rd_reg;
            da_reg <= (fwd_res.improve && (ed_a == ed_b)) ? fwd_res.sum : dist_a_rd_reg;
        end
    end

    // end of one edge: advance edge, pass, or leave for the output phase
    logic edge_done;
    logic edge_last;
    logic pass_last;

    always_comb
    begin
        unique case (state_reg)
            S_DIST_RD: edge_done = !ed_ok;
            S_FWD:     edge_done = check_reg || directed_reg;
            S_REV:     edge_done = 1'b1;
            default:   edge_done = 1'b0;
        endcase
    end

    assign edge_last = (e_reg + bfsp_pkg::NE_W'(1)) == ne_eff;
    assign pass_last = (pass_reg + bfsp_pkg::NV_W'(1)) == (nv_eff - bfsp_pkg::NV_W'(1));

    // output register
    logic                              m_valid_reg;
    logic [bfsp_pkg::OUT_DATA_W-1:0]   m_data_reg;
    logic                              m_user_reg;
    logic                              m_last_reg;
    logic                              out_free;
    logic                              out_load;
    logic                              out_is_last;
    logic                              out_reached;

    assign out_free    = !m_valid_reg || m_tready;
    assign out_load    = (state_reg == S_OUT_LOAD) && out_free;
    assign out_is_last = (v_reg + bfsp_pkg::NV_W'(1)) == nv_eff;
    assign out_reached = reached_reg[v_reg[VW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            e_reg       <= '0;
            v_reg       <= '0;
            pass_reg    <= '0;
            check_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= 1'b0;
            m_last_reg  <= 1'b0;
        end
        else
        begin
            // Load a new word, or drop the one the receiver just took.
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            if (edge_done)
            begin
                if (!edge_last)
                begin
                    e_reg     <= e_reg + bfsp_pkg::NE_W'(1);
                    state_reg <= S_EDGE_RD;
                end
                else
                begin
                    e_reg <= '0;
                    if (check_reg)
                    begin
                        v_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        if (pass_last)
                            check_reg <= 1'b1;
                        pass_reg  <= pass_reg + bfsp_pkg::NV_W'(1);
                        state_reg <= S_EDGE_RD;
                    end
                end
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (in_accept && (s_tuser == bfsp_pkg::ACT_RUN))
                            state_reg <= S_INIT;
                    end
                    S_INIT:
                    begin
                        e_reg     <= '0;
                        v_reg     <= '0;
                        pass_reg  <= '0;
                        check_reg <= (nv_eff == bfsp_pkg::NV_W'(1));
                        if (!src_ok || (ne_eff == '0))
                            state_reg <= S_OUT_RD;
                        else
                            state_reg <= S_EDGE_RD;
                    end
                    S_EDGE_RD:  state_reg <= S_DIST_RD;
                    S_DIST_RD:  state_reg <= S_FWD;
                    S_FWD:      state_reg <= S_REV;
                    S_REV:      state_reg <= S_EDGE_RD;
                    S_OUT_RD:   state_reg <= S_OUT_LOAD;
                    S_OUT_LOAD:
                    begin
                        if (out_free)
                        begin
                            m_data_reg  <= {1'b0, out_reached,
                                            out_reached ? dist_a_rd_reg : {DW{1'b0}},
                                            VF'(v_reg)};
                            m_user_reg  <= cycle_reg;
                            m_last_reg  <= out_is_last;
                            if (out_is_last)
                                state_reg <= S_IDLE;
                            else
                            begin
                                v_reg     <= v_reg + bfsp_pkg::NV_W'(1);
                                state_reg <= S_OUT_RD;
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // A pending word that is not the last one means the output phase is live.
    a_out_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_last_reg) |-> (state_reg == S_OUT_RD || state_reg == S_OUT_LOAD))
        else $error("non-final result pending outside output phase");

    // The reverse step only follows a forward step of an undirected search.
    a_rev_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REV) |-> ($past(state_reg) == S_FWD && !directed_reg))
        else $error("reverse relaxation out of order");

    // The edge walk never runs past the edge count.
    a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDGE_RD) |-> (e_reg < ne_eff))
        else $error("edge counter beyond edge count");

    // The source stays reached throughout the relaxation passes.
    a_src_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FWD) |-> reached_reg[source_reg[VW-1:0]])
        else $error("source lost its reached flag");

endmodule
